// ----- rtl/rsb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsb_pkg
// Shared types, constants and helpers for the retransmit slot buffer.
// ----------------------------------------------------------------------------
package rsb_pkg;

    localparam int SLOT_COUNT   = 16;
    localparam int PAYLOAD_BITS = 64;

    localparam int IDX_W   = $clog2(SLOT_COUNT);
    localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
    localparam int REM_W   = IDX_W + 1;
    localparam int ID_W    = 32;
    localparam int CFG_W   = 5;

    // two quotient bits retired per cycle
    localparam int DIV_CYCLES = ID_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] packet_id;
        logic [15:0] seq_number;
        logic [31:0] time_stamp;
        logic [15:0] length_tag;
        logic [63:0] payload_word;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_id;
        logic [15:0] found_seq;
        logic [31:0] found_time;
        logic [15:0] found_length;
        logic [63:0] found_payload;
    } t_rsp;

    typedef struct packed {
        logic [31:0]             id;
        logic [15:0]             seq;
        logic [31:0]             stamp;
        logic [15:0]             length;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_slot;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       wr_en;
        logic       clr_all;
        logic       pos_init;
        logic       rd_en;
        logic       pos_adv;
        logic       emit;
        logic       found;
        logic [1:0] status;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       home_valid;
        logic       single;
        logic       hit;
        logic       last;
    } t_sts;

    function automatic logic [CNT_W-1:0] slots_used(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] n;
        if (v == '0) begin
            n = CNT_W'(1);
        end else if (32'(v) > SLOT_COUNT) begin
            n = CNT_W'(SLOT_COUNT);
        end else begin
            n = CNT_W'(v);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/retransmit_slot_buffer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// retransmit_slot_buffer_top
// Slot store for resending lost packets: write, lookup and clear requests.
// ----------------------------------------------------------------------------
// Sequence: id modulo reduction (two bits a cycle), then a dispatch state; a
//   lookup then walks the slots after the home slot (read, compare each),
//   up to n-1 of them, where n is the number of slots in use.
// Throughput: one request at a time; busy is high from accept to result.
// The result is held for one cycle under o_valid; the receiver cannot stall.
// Reset: synchronous, clears all valid bits at once and sets slots in use to 16.
// ----------------------------------------------------------------------------
module retransmit_slot_buffer_top (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire rsb_pkg::t_req             i_req,
    output logic                           o_valid,
    output rsb_pkg::t_rsp                  o_rsp,
    input  wire logic                      i_cfg_we,
    input  wire logic [rsb_pkg::CFG_W-1:0] i_cfg_wdata
);

    rsb_pkg::t_ctl ctl;
    rsb_pkg::t_sts sts;

    rsb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_ctl   (ctl),
        .i_sts   (sts)
    );

    rsb_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_rsp       (o_rsp)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result strobe outside end of request");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(ctl.found)) |->
            (o_rsp.found_id == '0 && o_rsp.found_payload == '0))
        else $error("found fields not zero without a match");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({ctl.wr_en, ctl.clr_all, ctl.pos_init, ctl.rd_en, ctl.pos_adv}))
        else $error("conflicting datapath commands");

endmodule
`default_nettype wire

// ----- rtl/rsb_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsb_ctrl
// Sequencer: home slot reduction, command dispatch and ring walk.
// ----------------------------------------------------------------------------
module rsb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    output logic               o_valid,
    output rsb_pkg::t_ctl      o_ctl,
    input  wire rsb_pkg::t_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_DISP,
        S_READ,
        S_CMP
    } t_state;

    t_state                          r_state, n_state;
    logic [rsb_pkg::DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic                            r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_valid = 1'b0;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_ctl.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_ctl.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == rsb_pkg::DIV_CNT_W'(rsb_pkg::DIV_CYCLES - 1)) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.cmd)
                    rsb_pkg::CMD_WRITE: begin
                        o_ctl.wr_en  = 1'b1;
                        o_ctl.emit   = 1'b1;
                        o_ctl.status = rsb_pkg::ST_OK;
                        n_valid      = 1'b1;
                        n_state      = S_IDLE;
                    end
                    rsb_pkg::CMD_CLEAR: begin
                        o_ctl.clr_all = 1'b1;
                        o_ctl.emit    = 1'b1;
                        o_ctl.status  = rsb_pkg::ST_OK;
                        n_valid       = 1'b1;
                        n_state       = S_IDLE;
                    end
                    rsb_pkg::CMD_LOOKUP: begin
                        if (!i_sts.home_valid) begin
                            o_ctl.emit   = 1'b1;
                            o_ctl.status = rsb_pkg::ST_EMPTY;
                            n_valid      = 1'b1;
                            n_state      = S_IDLE;
                        end else if (i_sts.single) begin
                            o_ctl.emit   = 1'b1;
                            o_ctl.status = rsb_pkg::ST_NOMATCH;
                            n_valid      = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            o_ctl.pos_init = 1'b1;
                            n_state        = S_READ;
                        end
                    end
                    default: begin
                        o_ctl.emit   = 1'b1;
                        o_ctl.status = rsb_pkg::ST_OK;
                        n_valid      = 1'b1;
                        n_state      = S_IDLE;
                    end
                endcase
            end
            S_READ: begin
                o_ctl.rd_en = 1'b1;
                n_state     = S_CMP;
            end
            S_CMP: begin
                if (i_sts.hit) begin
                    o_ctl.emit   = 1'b1;
                    o_ctl.found  = 1'b1;
                    o_ctl.status = rsb_pkg::ST_OK;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_sts.last) begin
                    o_ctl.emit   = 1'b1;
                    o_ctl.status = rsb_pkg::ST_NOMATCH;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_ctl.pos_adv = 1'b1;
                    n_state       = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule
`default_nettype wire

// ----- rtl/rsb_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsb_datapath
// Slot store, valid bits, id modulo reduction, walk pointer and result register.
// ----------------------------------------------------------------------------
module rsb_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [rsb_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire rsb_pkg::t_req                 i_req,
    input  wire rsb_pkg::t_ctl                 i_ctl,
    output rsb_pkg::t_sts                      o_sts,
    output rsb_pkg::t_rsp                      o_rsp
);

    localparam int IDX_W = rsb_pkg::IDX_W;
    localparam int REM_W = rsb_pkg::REM_W;
    localparam int CNT_W = rsb_pkg::CNT_W;

    logic [rsb_pkg::CFG_W-1:0]       r_entries;
    logic [rsb_pkg::SLOT_COUNT-1:0]  r_slot_vld;
    rsb_pkg::t_slot                  r_mem [rsb_pkg::SLOT_COUNT];

    rsb_pkg::t_req                   r_req;
    logic [CNT_W-1:0]                r_n;
    logic [rsb_pkg::ID_W-1:0]        r_id_sh;
    logic [IDX_W-1:0]                r_rem;
    logic [IDX_W-1:0]                r_pos;
    rsb_pkg::t_slot                  r_rd;
    logic                            r_rd_vld;
    logic                            r_rd_last;
    rsb_pkg::t_rsp                   r_rsp;

    logic [IDX_W-1:0]                rem_a, rem_b;
    logic [IDX_W-1:0]                home_next, pos_next;

    function automatic logic [IDX_W-1:0] mod_step(input logic [IDX_W-1:0] r,
                                                 input logic b,
                                                 input logic [CNT_W-1:0] n);
        logic [REM_W-1:0] t;
        t = {r, b};
        if (t >= REM_W'(n)) begin
            t = t - REM_W'(n);
        end
        return t[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p,
                                                  input logic [CNT_W-1:0] n);
        logic [REM_W-1:0] q;
        q = REM_W'(p) + REM_W'(1);
        if (q >= REM_W'(n)) begin
            q = '0;
        end
        return q[IDX_W-1:0];
    endfunction

    assign rem_a     = mod_step(r_rem, r_id_sh[rsb_pkg::ID_W-1], r_n);
    assign rem_b     = mod_step(rem_a, r_id_sh[rsb_pkg::ID_W-2], r_n);
    assign home_next = ring_next(r_rem, r_n);
    assign pos_next  = ring_next(r_pos, r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries  <= rsb_pkg::CFG_RESET;
            r_slot_vld <= '0;
        end else begin
            if (i_cfg_we) begin
                r_entries <= i_cfg_wdata;
            end
            if (i_ctl.clr_all) begin
                r_slot_vld <= '0;
            end else if (i_ctl.wr_en) begin
                r_slot_vld[r_rem] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[r_rem] <= '{id:      r_req.packet_id,
                              seq:     r_req.seq_number,
                              stamp:   r_req.time_stamp,
                              length:  r_req.length_tag,
                              payload: r_req.payload_word[rsb_pkg::PAYLOAD_BITS-1:0]};
        end
        if (i_ctl.rd_en) begin
            r_rd <= r_mem[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_req   <= i_req;
            r_n     <= rsb_pkg::slots_used(r_entries);
            r_id_sh <= i_req.packet_id;
            r_rem   <= '0;
        end
        if (i_ctl.div_step) begin
            r_rem   <= rem_b;
            r_id_sh <= {r_id_sh[rsb_pkg::ID_W-3:0], 2'b00};
        end
        if (i_ctl.pos_init) begin
            r_pos <= home_next;
        end else if (i_ctl.pos_adv) begin
            r_pos <= pos_next;
        end
        if (i_ctl.rd_en) begin
            r_rd_vld  <= r_slot_vld[r_pos];
            r_rd_last <= (pos_next == r_rem);
        end
        if (i_ctl.emit) begin
            r_rsp <= '{status:        i_ctl.status,
                       found_id:      i_ctl.found ? r_rd.id : 32'd0,
                       found_seq:     i_ctl.found ? r_rd.seq : 16'd0,
                       found_time:    i_ctl.found ? r_rd.stamp : 32'd0,
                       found_length:  i_ctl.found ? r_rd.length : 16'd0,
                       found_payload: i_ctl.found ? 64'(r_rd.payload) : 64'd0};
        end
    end

    assign o_sts.cmd        = r_req.cmd;
    assign o_sts.home_valid = r_slot_vld[r_rem];
    assign o_sts.single     = (home_next == r_rem);
    assign o_sts.hit        = r_rd_vld && (r_rd.stamp == r_req.time_stamp)
                              && (r_rd.seq == r_req.seq_number);
    assign o_sts.last       = r_rd_last;
    assign o_rsp            = r_rsp;

endmodule
`default_nettype wire
